/* rtl/assert_macros.svh */
// Assertion macros shared by the delta robot kinematics RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, ignored during reset.
`define DRI_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, ignored during reset.
`define DRI_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/dri_pkg.sv */
// Types, widths, constants and the CORDIC angle table for the delta robot kinematics.
package dri_pkg;

  localparam int POS_W      = 20;
  localparam int LEN_W      = 19;
  localparam int LIM_W      = 9;
  localparam int ANG_W      = 17;
  localparam int TERM_W     = 48;
  localparam int NORM_W     = 31;
  localparam int ROOT_W     = 31;
  localparam int SQ_W       = 2 * ROOT_W;
  localparam int CORD_W     = 36;
  localparam int ZW         = 25;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 20;

  // pipeline depth of the term stages and of the arm solver without its CORDIC cells
  localparam int TERMS_LAT     = 4;
  localparam int ARM_FIXED_LAT = 4 + ROOT_W + 1 + 2;

  localparam logic signed [17:0]      SQRT3_Q16  = 18'sd113512;
  localparam logic signed [ANG_W-1:0] FAIL_ANGLE = -17'sd25600;
  localparam logic signed [ANG_W-1:0] ANGLE_MAX  = 17'sd46080;

  localparam logic [CFG_IDX_W-1:0] REG_ARM_LENGTH = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_A   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_B   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_C   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ANGLE_LOW  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ANGLE_HIGH = 3'd5;

  typedef logic signed [POS_W-1:0]   pos_t;
  typedef logic signed [2*POS_W-1:0] prod_t;
  typedef logic signed [TERM_W-1:0]  term_t;
  typedef logic signed [NORM_W-1:0]  norm_t;
  typedef logic signed [CORD_W-1:0]  cord_t;
  typedef logic signed [ZW-1:0]      zang_t;
  typedef logic signed [ANG_W-1:0]   ang_t;

  typedef struct packed {
    logic ok;
    ang_t angle;
  } arm_result_t;

  // atan(2^-i) in degrees, Q.16
  function automatic zang_t atan_deg(input int unsigned i);
    zang_t v;
    case (i)
      0:  v = 25'sd2949120;
      1:  v = 25'sd1740967;
      2:  v = 25'sd919879;
      3:  v = 25'sd466945;
      4:  v = 25'sd234379;
      5:  v = 25'sd117304;
      6:  v = 25'sd58666;
      7:  v = 25'sd29335;
      8:  v = 25'sd14668;
      9:  v = 25'sd7334;
      10: v = 25'sd3667;
      11: v = 25'sd1833;
      12: v = 25'sd917;
      13: v = 25'sd458;
      14: v = 25'sd229;
      15: v = 25'sd115;
      16: v = 25'sd57;
      17: v = 25'sd29;
      18: v = 25'sd14;
      19: v = 25'sd7;
      20: v = 25'sd4;
      21: v = 25'sd2;
      22: v = 25'sd1;
      default: v = 25'sd0;
    endcase
    return v;
  endfunction

endpackage

/* rtl/dri_sqrt_cell.sv */
// One bit cell of the pipelined integer square root chain.
module dri_sqrt_cell import dri_pkg::*; #(
  parameter int BIT = 0,
  parameter int PW  = 1
) (
  input  logic              clk,
  input  logic              en,
  input  logic [SQ_W-1:0]   rem_in,
  input  logic [ROOT_W-1:0] root_in,
  input  logic [PW-1:0]     pay_in,
  output logic [SQ_W-1:0]   rem_out,
  output logic [ROOT_W-1:0] root_out,
  output logic [PW-1:0]     pay_out
);

  logic [SQ_W-1:0] trial;
  logic            take;

  // (root + 2^BIT)^2 - root^2
  always_comb begin
    trial = (SQ_W'(root_in) << (BIT + 1)) + (SQ_W'(1) << (2 * BIT));
    take  = rem_in >= trial;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_out  <= take ? rem_in - trial : rem_in;
      root_out <= take ? (root_in | (ROOT_W'(1) << BIT)) : root_in;
      pay_out  <= pay_in;
    end
  end

endmodule

/* rtl/dri_cordic_cell.sv */
// One rotation cell of the vectoring CORDIC chain.
module dri_cordic_cell import dri_pkg::*; #(
  parameter int STEP = 0,
  parameter int PW   = 1
) (
  input  logic          clk,
  input  logic          en,
  input  cord_t         x_in,
  input  cord_t         y_in,
  input  zang_t         z_in,
  input  logic [PW-1:0] pay_in,
  output cord_t         x_out,
  output cord_t         y_out,
  output zang_t         z_out,
  output logic [PW-1:0] pay_out
);

  cord_t xs;
  cord_t ys;

  always_comb begin
    xs = x_in >>> STEP;
    ys = y_in >>> STEP;
  end

  // rotate toward the x axis
  always_ff @(posedge clk) begin
    if (en) begin
      if (!y_in[CORD_W-1]) begin
        x_out <= x_in + ys;
        y_out <= y_in - xs;
        z_out <= z_in + atan_deg(STEP);
      end else begin
        x_out <= x_in - ys;
        y_out <= y_in + xs;
        z_out <= z_in - atan_deg(STEP);
      end
      pay_out <= pay_in;
    end
  end

endmodule

/* rtl/dri_terms.sv */
// Forms the E, F and G terms of all three arms from one position.
module dri_terms import dri_pkg::*; (
  input  logic             clk,
  input  logic             en,
  input  pos_t             pos_x,
  input  pos_t             pos_y,
  input  pos_t             pos_z,
  input  logic [LEN_W-1:0] arm_length,
  input  pos_t             offset_a,
  input  pos_t             offset_b,
  input  pos_t             offset_c,
  output term_t            e0,
  output term_t            e1,
  output term_t            e2,
  output term_t            f,
  output term_t            g0,
  output term_t            g1,
  output term_t            g2
);

  logic signed [POS_W:0]   s1_xpb, s1_xmb, s1_ya, s1_yc;
  prod_t                   s1_xx, s1_yy, s1_zz, s1_zl, s1_aa, s1_bb, s1_cc;
  prod_t                   s1_yap, s1_ycp, s1_xbp;

  term_t                   s2_sq, s2_t0, s2_t12, s2_xb2, s2_f;
  logic signed [POS_W+18:0] s2_r1p, s2_r2p;
  logic signed [POS_W:0]   s2_ya, s2_yc;

  term_t                   s3_g0, s3_g1, s3_g2, s3_f;
  logic signed [POS_W+4:0] s3_u1, s3_u2;
  logic signed [POS_W:0]   s3_ya;

  logic signed [POS_W+18:0] r1_rnd, r2_rnd;
  logic signed [LEN_W:0]   len_s;
  logic signed [LEN_W+POS_W+1:0] p0;
  logic signed [LEN_W+POS_W+5:0] p1, p2;

  always_comb begin
    len_s  = {1'b0, arm_length};
    r1_rnd = s2_r1p + 39'sd32768;
    r2_rnd = s2_r2p + 39'sd32768;
    p0     = len_s * s3_ya;
    p1     = len_s * s3_u1;
    p2     = len_s * s3_u2;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // products and offset sums
      s1_xpb <= {pos_x[POS_W-1], pos_x} + {offset_b[POS_W-1], offset_b};
      s1_xmb <= {pos_x[POS_W-1], pos_x} - {offset_b[POS_W-1], offset_b};
      s1_ya  <= {pos_y[POS_W-1], pos_y} + {offset_a[POS_W-1], offset_a};
      s1_yc  <= {pos_y[POS_W-1], pos_y} + {offset_c[POS_W-1], offset_c};
      s1_xx  <= pos_x * pos_x;
      s1_yy  <= pos_y * pos_y;
      s1_zz  <= pos_z * pos_z;
      s1_zl  <= pos_z * len_s;
      s1_aa  <= offset_a * offset_a;
      s1_bb  <= offset_b * offset_b;
      s1_cc  <= offset_c * offset_c;
      s1_yap <= pos_y * offset_a;
      s1_ycp <= pos_y * offset_c;
      s1_xbp <= pos_x * offset_b;

      // partial sums of G, sqrt3 products
      s2_sq  <= term_t'(s1_xx) + term_t'(s1_yy) + term_t'(s1_zz);
      s2_t0  <= term_t'(s1_aa) + (term_t'(s1_yap) <<< 1);
      s2_t12 <= term_t'(s1_bb) + term_t'(s1_cc) + (term_t'(s1_ycp) <<< 1);
      s2_xb2 <= term_t'(s1_xbp) <<< 1;
      s2_f   <= term_t'(s1_zl) <<< 1;
      s2_r1p <= s1_xpb * SQRT3_Q16;
      s2_r2p <= s1_xmb * SQRT3_Q16;
      s2_ya  <= s1_ya;
      s2_yc  <= s1_yc;

      // G terms and the bracketed E factors
      s3_g0 <= s2_sq + s2_t0;
      s3_g1 <= s2_sq + s2_t12 + s2_xb2;
      s3_g2 <= s2_sq + s2_t12 - s2_xb2;
      s3_f  <= s2_f;
      s3_u1 <= (POS_W+5)'(signed'(r1_rnd[POS_W+18:16])) + (POS_W+5)'(s2_yc);
      s3_u2 <= (POS_W+5)'(signed'(r2_rnd[POS_W+18:16])) - (POS_W+5)'(s2_yc);
      s3_ya <= s2_ya;

      // scale by the arm length
      e0 <= term_t'(p0) <<< 1;
      e1 <= -term_t'(p1);
      e2 <= term_t'(p2);
      f  <= s3_f;
      g0 <= s3_g0;
      g1 <= s3_g1;
      g2 <= s3_g2;
    end
  end

endmodule

/* rtl/dri_arm.sv */
// Root solver of one arm: normalise, discriminant, square root chain, two CORDIC chains.
module dri_arm import dri_pkg::*; #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic                    clk,
  input  logic                    en,
  input  term_t                   e,
  input  term_t                   f,
  input  term_t                   g,
  input  logic signed [LIM_W-1:0] angle_low_limit,
  input  logic signed [LIM_W-1:0] angle_high_limit,
  output arm_result_t             result
);

  localparam int SH_MAX = TERM_W - NORM_W + 1;
  localparam int SH_W   = $clog2(SH_MAX + 1);
  localparam int SPW    = 2 + NORM_W + NORM_W + 1;
  localparam int N_W    = NORM_W + 2;

  function automatic ang_t round_sat(input zang_t z, input logic zero);
    logic signed [ZW+1:0] t;
    logic signed [ZW-7:0] a;
    ang_t                 r;
    t = {z[ZW-1], z, 1'b0} + (ZW+2)'(128);
    a = t[ZW+1:8];
    if (zero) begin
      r = '0;
    end else if (a > (ZW-6)'(ANGLE_MAX)) begin
      r = ANGLE_MAX;
    end else if (a < -(ZW-6)'(ANGLE_MAX)) begin
      r = -ANGLE_MAX;
    end else begin
      r = a[ANG_W-1:0];
    end
    return r;
  endfunction

  // normalise
  logic [TERM_W-1:0] me, mf, mg, mx;
  logic [SH_W-1:0]   sh;
  term_t             a1_e, a1_f, a1_g, se, sf, sg;
  logic [SH_W-1:0]   a1_sh;
  logic              a1_eq;

  always_comb begin
    me = e[TERM_W-1] ? TERM_W'(-e) : TERM_W'(e);
    mf = f[TERM_W-1] ? TERM_W'(-f) : TERM_W'(f);
    mg = g[TERM_W-1] ? TERM_W'(-g) : TERM_W'(g);
    mx = me;
    if (mf > mx) mx = mf;
    if (mg > mx) mx = mg;
    sh = '0;
    for (int i = 0; i < SH_MAX; i++) begin
      if (|(mx >> (NORM_W - 1 + i))) sh = SH_W'(i + 1);
    end
    se = a1_e >>> a1_sh;
    sf = a1_f >>> a1_sh;
    sg = a1_g >>> a1_sh;
  end

  norm_t a2_e, a2_f, a2_g;
  logic  a2_eq;
  logic signed [2*NORM_W-1:0] a3_ff, a3_ee, a3_gg;
  logic signed [NORM_W:0]     a3_den;
  norm_t a3_f;
  logic  a3_eq;
  logic signed [SQ_W+1:0] disc;
  logic [SQ_W-1:0] a4_rem;
  logic [SPW-1:0]  a4_pay;

  always_comb begin
    disc = (SQ_W+2)'(a3_ff) + (SQ_W+2)'(a3_ee) - (SQ_W+2)'(a3_gg);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a1_e  <= e;
      a1_f  <= f;
      a1_g  <= g;
      a1_sh <= sh;
      a1_eq <= (g == e);

      a2_e  <= se[NORM_W-1:0];
      a2_f  <= sf[NORM_W-1:0];
      a2_g  <= sg[NORM_W-1:0];
      a2_eq <= a1_eq;

      a3_ff  <= a2_f * a2_f;
      a3_ee  <= a2_e * a2_e;
      a3_gg  <= a2_g * a2_g;
      a3_den <= {a2_g[NORM_W-1], a2_g} - {a2_e[NORM_W-1], a2_e};
      a3_f   <= a2_f;
      a3_eq  <= a2_eq;

      a4_rem <= disc[SQ_W-1:0];
      a4_pay <= {a3_eq, disc[SQ_W+1], a3_f, a3_den};
    end
  end

  // square root, one result bit per cell
  logic [SQ_W-1:0]   rem_c  [ROOT_W+1];
  logic [ROOT_W-1:0] root_c [ROOT_W+1];
  logic [SPW-1:0]    pay_c  [ROOT_W+1];

  assign rem_c[0]  = a4_rem;
  assign root_c[0] = '0;
  assign pay_c[0]  = a4_pay;

  for (genvar j = 0; j < ROOT_W; j++) begin : g_sqrt
    dri_sqrt_cell #(.BIT(ROOT_W - 1 - j), .PW(SPW)) u_cell (
      .clk      (clk),
      .en       (en),
      .rem_in   (rem_c[j]),
      .root_in  (root_c[j]),
      .pay_in   (pay_c[j]),
      .rem_out  (rem_c[j+1]),
      .root_out (root_c[j+1]),
      .pay_out  (pay_c[j+1])
    );
  end

  // numerators, fold the vector into the right half plane
  logic                   q_eq, q_neg;
  norm_t                  q_f;
  logic signed [NORM_W:0] q_den;
  logic signed [N_W-1:0]  nf, sv, np, nm;
  cord_t                  cx, cyp, cym;

  always_comb begin
    {q_eq, q_neg, q_f, q_den} = pay_c[ROOT_W];
    nf  = -N_W'(q_f);
    sv  = {2'b00, root_c[ROOT_W]};
    np  = nf + sv;
    nm  = nf - sv;
    cx  = CORD_W'(q_den);
    cyp = CORD_W'(np);
    cym = CORD_W'(nm);
  end

  cord_t    xp_c [CORDIC_STEPS+1];
  cord_t    yp_c [CORDIC_STEPS+1];
  zang_t    zp_c [CORDIC_STEPS+1];
  logic [2:0] pp_c [CORDIC_STEPS+1];
  cord_t    xm_c [CORDIC_STEPS+1];
  cord_t    ym_c [CORDIC_STEPS+1];
  zang_t    zm_c [CORDIC_STEPS+1];
  logic [0:0] pm_c [CORDIC_STEPS+1];

  always_ff @(posedge clk) begin
    if (en) begin
      xp_c[0] <= q_den[NORM_W] ? -cx : cx;
      yp_c[0] <= q_den[NORM_W] ? -cyp : cyp;
      xm_c[0] <= q_den[NORM_W] ? -cx : cx;
      ym_c[0] <= q_den[NORM_W] ? -cym : cym;
      zp_c[0] <= '0;
      zm_c[0] <= '0;
      pp_c[0] <= {q_eq, q_neg, np == '0};
      pm_c[0] <= nm == '0;
    end
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
    dri_cordic_cell #(.STEP(i), .PW(3)) u_plus (
      .clk     (clk),
      .en      (en),
      .x_in    (xp_c[i]),
      .y_in    (yp_c[i]),
      .z_in    (zp_c[i]),
      .pay_in  (pp_c[i]),
      .x_out   (xp_c[i+1]),
      .y_out   (yp_c[i+1]),
      .z_out   (zp_c[i+1]),
      .pay_out (pp_c[i+1])
    );
    dri_cordic_cell #(.STEP(i), .PW(1)) u_minus (
      .clk     (clk),
      .en      (en),
      .x_in    (xm_c[i]),
      .y_in    (ym_c[i]),
      .z_in    (zm_c[i]),
      .pay_in  (pm_c[i]),
      .x_out   (xm_c[i+1]),
      .y_out   (ym_c[i+1]),
      .z_out   (zm_c[i+1]),
      .pay_out (pm_c[i+1])
    );
  end

  // double, round, saturate, then pick the first root inside the limits
  ang_t b_ap, b_am;
  logic b_eq, b_neg;
  ang_t lo, hi;
  logic okp, okm;

  always_comb begin
    lo  = {angle_low_limit, 8'b0};
    hi  = {angle_high_limit, 8'b0};
    okp = (b_ap >= lo) && (b_ap <= hi);
    okm = (b_am >= lo) && (b_am <= hi);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_ap  <= round_sat(zp_c[CORDIC_STEPS], pp_c[CORDIC_STEPS][0]);
      b_am  <= round_sat(zm_c[CORDIC_STEPS], pm_c[CORDIC_STEPS][0]);
      b_eq  <= pp_c[CORDIC_STEPS][2];
      b_neg <= pp_c[CORDIC_STEPS][1];

      result.ok    <= !b_eq && !b_neg && (okp || okm);
      result.angle <= okp ? b_ap : b_am;
    end
  end

endmodule

/* rtl/delta_robot_inverse_kinematics.sv */
// Throughput: one request per cycle while no blocked result stalls the pipeline, set by
// the bit-per-cell square root chain and the step-per-cell CORDIC chains, which all
// advance together.
// A finished result waits in the output register while the pipeline keeps filling.
// Reset (synchronous, rst high) empties the pipeline and loads the default registers.
// Configuration writes are registered directly and must be made while the block is idle.
`include "assert_macros.svh"
module delta_robot_inverse_kinematics import dri_pkg::*; #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  pos_t                  pos_x,
  input  pos_t                  pos_y,
  input  pos_t                  pos_z,
  output logic                  out_valid,
  input  logic                  out_stall,
  output ang_t                  angle_arm_one,
  output ang_t                  angle_arm_two,
  output ang_t                  angle_arm_three,
  output logic                  reachable
);

  localparam int LAT = TERMS_LAT + ARM_FIXED_LAT + CORDIC_STEPS;

  logic [LEN_W-1:0]        arm_length;
  pos_t                    offset_a, offset_b, offset_c;
  logic signed [LIM_W-1:0] angle_low_limit, angle_high_limit;

  always_ff @(posedge clk) begin
    if (rst) begin
      arm_length       <= 19'd2560;
      offset_a         <= 20'sd512;
      offset_b         <= 20'sd768;
      offset_c         <= 20'sd1024;
      angle_low_limit  <= -9'sd45;
      angle_high_limit <= 9'sd90;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_ARM_LENGTH: arm_length       <= cfg_data[LEN_W-1:0];
        REG_OFFSET_A:   offset_a         <= cfg_data;
        REG_OFFSET_B:   offset_b         <= cfg_data;
        REG_OFFSET_C:   offset_c         <= cfg_data;
        REG_ANGLE_LOW:  angle_low_limit  <= cfg_data[LIM_W-1:0];
        REG_ANGLE_HIGH: angle_high_limit <= cfg_data[LIM_W-1:0];
        default: ;
      endcase
    end
  end

  logic [LAT-1:0] vld;
  logic           en;
  logic           out_free;

  // hold the pipeline only when its last stage cannot drain into the output register
  assign out_free = !out_valid || !out_stall;
  assign en       = !vld[LAT-1] || out_free;
  assign in_stall = !en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], in_valid};
    end
  end

  term_t e0, e1, e2, f, g0, g1, g2;

  dri_terms u_terms (
    .clk        (clk),
    .en         (en),
    .pos_x      (pos_x),
    .pos_y      (pos_y),
    .pos_z      (pos_z),
    .arm_length (arm_length),
    .offset_a   (offset_a),
    .offset_b   (offset_b),
    .offset_c   (offset_c),
    .e0         (e0),
    .e1         (e1),
    .e2         (e2),
    .f          (f),
    .g0         (g0),
    .g1         (g1),
    .g2         (g2)
  );

  arm_result_t res0, res1, res2;

  dri_arm #(.CORDIC_STEPS(CORDIC_STEPS)) u_arm0 (
    .clk (clk), .en (en), .e (e0), .f (f), .g (g0),
    .angle_low_limit (angle_low_limit), .angle_high_limit (angle_high_limit),
    .result (res0)
  );

  dri_arm #(.CORDIC_STEPS(CORDIC_STEPS)) u_arm1 (
    .clk (clk), .en (en), .e (e1), .f (f), .g (g1),
    .angle_low_limit (angle_low_limit), .angle_high_limit (angle_high_limit),
    .result (res1)
  );

  dri_arm #(.CORDIC_STEPS(CORDIC_STEPS)) u_arm2 (
    .clk (clk), .en (en), .e (e2), .f (f), .g (g2),
    .angle_low_limit (angle_low_limit), .angle_high_limit (angle_high_limit),
    .result (res2)
  );

  logic all_ok;
  assign all_ok = res0.ok && res1.ok && res2.ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= vld[LAT-1];
    end
  end

  // one failing arm fails the whole request
  always_ff @(posedge clk) begin
    if (out_free) begin
      angle_arm_one   <= all_ok ? res0.angle : FAIL_ANGLE;
      angle_arm_two   <= all_ok ? res1.angle : FAIL_ANGLE;
      angle_arm_three <= all_ok ? res2.angle : FAIL_ANGLE;
      reachable       <= all_ok;
    end
  end

  `DRI_ASSERT_NEXT(a_accept_enters, (in_valid && !in_stall), vld[0], "accepted request lost at entry")
  `DRI_ASSERT_IMPLY(a_stall_when_full, in_stall, (vld[LAT-1] && out_valid && out_stall), "stall without a blocked result")
  `DRI_ASSERT_IMPLY(a_fail_angles, (out_valid && !reachable), (angle_arm_one == FAIL_ANGLE && angle_arm_two == FAIL_ANGLE && angle_arm_three == FAIL_ANGLE), "unreachable request with live angles")

endmodule
